[hdl/month_calendar_grid_macros.svh]
// Assertion macros for the month calendar grid block.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef MONTH_CALENDAR_GRID_MACROS_SVH
`define MONTH_CALENDAR_GRID_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MCG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MCG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mcg_pkg.sv]
// Package for the month calendar grid: constants, microcode types and tables.
// Depends on nothing; used by month_calendar_grid.
`default_nettype none

package mcg_pkg;

  localparam int BASE_YEAR  = 1583;
  localparam int END_YEAR   = 4040;
  localparam int GRID_WIDTH = 7;
  localparam int BASE_WDAY  = 6;

  localparam logic [11:0] BASE_YEAR_W = 12'(BASE_YEAR);
  localparam logic [11:0] END_YEAR_W  = 12'(END_YEAR);
  localparam logic [12:0] BASE_YEAR_X = 13'(BASE_YEAR);
  localparam logic [12:0] LEAP_BASE   =
    13'((BASE_YEAR - 1) / 4 - (BASE_YEAR - 1) / 100 + (BASE_YEAR - 1) / 400);
  localparam logic [3:0]  MONTH_MAX   = 4'd11;
  localparam logic [2:0]  COL_LAST    = 3'(GRID_WIDTH - 1);
  localparam logic [3:0]  BASE_WDAY_W = 4'(BASE_WDAY);
  localparam logic [3:0]  SEVEN       = 4'd7;

  localparam logic [24:0] RECIP100    = 25'd5243;
  localparam int          RECIP_SHIFT = 19;
  localparam logic [6:0]  HUNDRED     = 7'd100;

  typedef logic [3:0] step_t;

  localparam step_t STEP_WAIT = 4'd0;
  localparam step_t STEP_MULA = 4'd1;
  localparam step_t STEP_MULB = 4'd2;
  localparam step_t STEP_MULC = 4'd3;
  localparam step_t STEP_LEAP = 4'd4;
  localparam step_t STEP_SUM  = 4'd5;
  localparam step_t STEP_FLD0 = 4'd6;
  localparam step_t STEP_FLD1 = 4'd7;
  localparam step_t STEP_COL  = 4'd8;
  localparam step_t STEP_EMIT = 4'd9;

  typedef enum logic [3:0] {
    OP_WAIT, OP_MULA, OP_MULB, OP_MULC, OP_LEAP, OP_SUM, OP_FOLD, OP_COL, OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    COND_ALWAYS, COND_START, COND_LAST
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ctrl_t;

  // Each word either jumps to its target when its condition holds or stays put.
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    unique case (step)
      STEP_WAIT: w = '{op: OP_WAIT, cond: COND_START,  target: STEP_MULA};
      STEP_MULA: w = '{op: OP_MULA, cond: COND_ALWAYS, target: STEP_MULB};
      STEP_MULB: w = '{op: OP_MULB, cond: COND_ALWAYS, target: STEP_MULC};
      STEP_MULC: w = '{op: OP_MULC, cond: COND_ALWAYS, target: STEP_LEAP};
      STEP_LEAP: w = '{op: OP_LEAP, cond: COND_ALWAYS, target: STEP_SUM};
      STEP_SUM:  w = '{op: OP_SUM,  cond: COND_ALWAYS, target: STEP_FLD0};
      STEP_FLD0: w = '{op: OP_FOLD, cond: COND_ALWAYS, target: STEP_FLD1};
      STEP_FLD1: w = '{op: OP_FOLD, cond: COND_ALWAYS, target: STEP_COL};
      STEP_COL:  w = '{op: OP_COL,  cond: COND_ALWAYS, target: STEP_EMIT};
      STEP_EMIT: w = '{op: OP_EMIT, cond: COND_LAST,   target: STEP_WAIT};
      default:   w = '{op: OP_WAIT, cond: COND_ALWAYS, target: STEP_WAIT};
    endcase
    return w;
  endfunction

  // Days before the month in a common year, modulo 7.
  function automatic logic [2:0] month_offset(input logic [3:0] month);
    logic [2:0] r;
    case (month)
      4'd0:    r = 3'd0;
      4'd1:    r = 3'd3;
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd6;
      4'd4:    r = 3'd1;
      4'd5:    r = 3'd4;
      4'd6:    r = 3'd6;
      4'd7:    r = 3'd2;
      4'd8:    r = 3'd5;
      4'd9:    r = 3'd0;
      4'd10:   r = 3'd3;
      4'd11:   r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
    logic [4:0] r;
    case (month)
      4'd1:                       r = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:    r = 5'd30;
      default:                    r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/month_calendar_grid.sv]
// Month calendar grid: a small microcoded sequencer over a plain datapath.
// Depends on mcg_pkg and month_calendar_grid_macros.svh.
//
// Usage: a transaction on the input channel carries a year and a month index
// (0 is January). The block answers with one output transaction per day of
// that month, giving the day number, its grid row and its weekday column
// (0 is Sunday), with last_day_o set on the final day. Years outside 1583 to
// 4040 are clamped to that range. A month index above 11 is accepted and
// produces no output.
// Sequence: the control steps MULA, MULB, MULC, LEAP, SUM, FLD0, FLD1 and COL
// run before the first day is offered, three of them on the shared reciprocal
// multiplier that splits the year by 100 and 400. After that the emit step
// offers one day per cycle while the receiver does not stall. Input stall
// is high whenever the step counter is off its wait step, so one request is
// in flight at a time.
// A receiver stall holds the output register and freezes the emit step.
// Reset clears the step counter and the output valid; no memory needs a
// clearing pass.
`default_nettype none

module month_calendar_grid
  import mcg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [11:0] year_i,
  input  wire logic [3:0]  month_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [4:0]       day_number_o,
  output logic [2:0]       week_row_o,
  output logic [2:0]       weekday_column_o,
  output logic             last_day_o
);

  step_t       step_q, step_d;
  ctrl_t       ctrl;
  logic        cond_ok;
  logic        emit_fire;
  logic        is_last;

  logic [11:0] yr_q, yr_d;
  logic [3:0]  mon_q, mon_d;
  logic [24:0] prod_q, prod_d;
  logic [5:0]  q100_q, q100_d;
  logic [5:0]  q400_q, q400_d;
  logic        leap_q, leap_d;
  logic [11:0] tot_q, tot_d;
  logic [4:0]  day_q, day_d;
  logic [4:0]  len_q, len_d;
  logic [2:0]  row_q, row_d;
  logic [2:0]  col_q, col_d;

  logic        out_valid_q, out_valid_d;
  logic [4:0]  out_day_q;
  logic [2:0]  out_row_q;
  logic [2:0]  out_col_q;
  logic        out_last_q;

  logic [11:0] yr_m1;
  logic [5:0]  q100y;
  logic [12:0] hund_y;
  logic        div100;
  logic [12:0] base_sum;
  logic [3:0]  rem7;
  logic [3:0]  wday;

  assign ctrl       = ucode(step_q);
  assign in_stall_o = (ctrl.op != OP_WAIT);
  assign emit_fire  = (ctrl.op == OP_EMIT) && (!out_valid_q || !out_stall_i);
  assign is_last    = (day_q == len_q);

  always_comb begin
    case (ctrl.cond)
      COND_START:  cond_ok = in_valid_i && (month_i <= MONTH_MAX);
      COND_LAST:   cond_ok = emit_fire && is_last;
      default:     cond_ok = 1'b1;
    endcase
    step_d = cond_ok ? ctrl.target : step_q;
  end

  assign yr_m1    = yr_q - 12'd1;
  assign q100y    = prod_q[RECIP_SHIFT +: 6];
  assign hund_y   = 13'(q100y * HUNDRED);
  assign div100   = (hund_y == {1'b0, yr_q});
  assign base_sum = {1'b0, yr_q} - BASE_YEAR_X + {3'b0, yr_m1[11:2]}
                    - {7'b0, q100_q} + {7'b0, q400_q} - LEAP_BASE;
  assign rem7     = (tot_q[3:0] >= SEVEN) ? (tot_q[3:0] - SEVEN) : tot_q[3:0];
  assign wday     = rem7 + BASE_WDAY_W;

  always_comb begin
    yr_d   = yr_q;
    mon_d  = mon_q;
    prod_d = prod_q;
    q100_d = q100_q;
    q400_d = q400_q;
    leap_d = leap_q;
    tot_d  = tot_q;
    day_d  = day_q;
    len_d  = len_q;
    row_d  = row_q;
    col_d  = col_q;
    unique case (ctrl.op)
      OP_WAIT: begin
        if (year_i < BASE_YEAR_W) begin
          yr_d = BASE_YEAR_W;
        end else if (year_i > END_YEAR_W) begin
          yr_d = END_YEAR_W;
        end else begin
          yr_d = year_i;
        end
        mon_d = month_i;
      end
      OP_MULA: prod_d = {13'b0, yr_m1} * RECIP100;
      OP_MULB: begin
        q100_d = prod_q[RECIP_SHIFT +: 6];
        prod_d = {15'b0, yr_m1[11:2]} * RECIP100;
      end
      OP_MULC: begin
        q400_d = prod_q[RECIP_SHIFT +: 6];
        prod_d = {13'b0, yr_q} * RECIP100;
      end
      OP_LEAP: begin
        leap_d = (yr_q[1:0] == 2'b00) && (!div100 || (q100y[1:0] == 2'b00));
        tot_d  = base_sum[11:0];
      end
      OP_SUM: begin
        tot_d = tot_q + {9'b0, month_offset(mon_q)}
                + {11'b0, leap_q && (mon_q >= 4'd2)};
      end
      OP_FOLD: begin
        tot_d = {7'b0, {2'b0, tot_q[2:0]} + {2'b0, tot_q[5:3]}
                       + {2'b0, tot_q[8:6]} + {2'b0, tot_q[11:9]}};
      end
      OP_COL: begin
        col_d = (wday >= SEVEN) ? 3'(wday - SEVEN) : wday[2:0];
        row_d = 3'd0;
        day_d = 5'd1;
        len_d = month_length(mon_q, leap_q);
      end
      OP_EMIT: begin
        if (emit_fire) begin
          day_d = day_q + 5'd1;
          if (col_q == COL_LAST) begin
            col_d = 3'd0;
            row_d = row_q + 3'd1;
          end else begin
            col_d = col_q + 3'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (emit_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_WAIT;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    yr_q   <= yr_d;
    mon_q  <= mon_d;
    prod_q <= prod_d;
    q100_q <= q100_d;
    q400_q <= q400_d;
    leap_q <= leap_d;
    tot_q  <= tot_d;
    day_q  <= day_d;
    len_q  <= len_d;
    row_q  <= row_d;
    col_q  <= col_d;
    if (emit_fire) begin
      out_day_q  <= day_q;
      out_row_q  <= row_q;
      out_col_q  <= col_q;
      out_last_q <= is_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign day_number_o     = out_day_q;
  assign week_row_o       = out_row_q;
  assign weekday_column_o = out_col_q;
  assign last_day_o       = out_last_q;

`include "month_calendar_grid_macros.svh"

  `MCG_ASSERT_NOW(a_cell_range, out_valid_o, (day_number_o != 5'd0) && (week_row_o <= 3'd5) && (weekday_column_o <= COL_LAST), "Grid cell out of range.")
  `MCG_ASSERT_NOW(a_last_len, out_valid_o && last_day_o, day_number_o >= 5'd28, "Month ended before day 28.")
  `MCG_ASSERT_NEXT(a_keep_emit, out_valid_o && !out_stall_i && !last_day_o, (step_q == STEP_EMIT) || last_day_o, "Sequencer left emit step before the last day.")

endmodule

`default_nettype wire
